[rtl/gaps_pkg.sv]
package gaps_pkg;

  localparam int GRID_W     = 8;
  localparam int GRID_H     = 8;
  localparam int COORD_W    = 3;
  localparam int CELL_W     = 6;
  localparam int CELLS      = GRID_W * GRID_H;
  localparam int LIST_DEPTH = 64;
  localparam int FRAC_BITS  = 8;
  localparam int MAX_OUT    = 64;
  localparam int G_W        = 7;
  localparam int D2_W       = 7;
  localparam int DIRS       = 8;

  localparam logic       OP_LOAD   = 1'b0;
  localparam logic       OP_QUERY  = 1'b1;
  localparam logic [1:0] CODE_WALK = 2'd0;
  localparam logic [1:0] CODE_WALL = 2'd1;

  // neighbor order: E, S, W, N, NE, SW, NW, SE
  localparam logic signed [3:0] STEP_DX [DIRS] = '{
    4'sd1, 4'sd0, -4'sd1, 4'sd0, 4'sd1, -4'sd1, -4'sd1, 4'sd1};
  localparam logic signed [3:0] STEP_DY [DIRS] = '{
    4'sd0, 4'sd1, 4'sd0, -4'sd1, -4'sd1, 4'sd1, -4'sd1, 4'sd1};

  typedef struct packed {
    logic in_rdy;
    logic grid_wr;
    logic q_init;
    logic goal_rd;
    logic open_seed;
    logic scan_clr;
    logic scan_step;
    logic pop;
    logic nb_rd;
    logic nb_next;
    logic sq_start;
    logic child_wr;
    logic bt_take;
    logic em_init;
    logic em_load;
    logic em_next;
    logic fail_load;
  } gaps_cmd_t;

  typedef struct packed {
    logic in_vld;
    logic in_op;
    logic goal_wall;
    logic live_zero;
    logic scan_more;
    logic scan_pend;
    logic closed_full;
    logic cur_goal;
    logic nb_in;
    logic d_last;
    logic child_ok;
    logic sq_done;
    logic bt_stop;
    logic out_vld;
    logic out_last;
  } gaps_sts_t;

endpackage

[rtl/gaps_if.sv]
interface gaps_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [2:0] cell_x;
  logic [2:0] cell_y;
  logic [1:0] cell_value;
  logic [2:0] start_x;
  logic [2:0] start_y;
  logic [2:0] goal_x;
  logic [2:0] goal_y;

  modport source (output valid, op, cell_x, cell_y, cell_value, start_x, start_y, goal_x,
                  goal_y, input ready);
  modport sink (input valid, op, cell_x, cell_y, cell_value, start_x, start_y, goal_x,
                goal_y, output ready);
endinterface

interface gaps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] path_x;
  logic [2:0] path_y;
  logic       found;
  logic       last;

  modport source (output valid, path_x, path_y, found, last, input ready);
  modport sink (input valid, path_x, path_y, found, last, output ready);
endinterface

[rtl/gaps_ram.sv]
module gaps_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/gaps_sqrt.sv]
module gaps_sqrt #(
  parameter int R_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [R_W-1:0]   rad,
  output logic             busy,
  output logic             done,
  output logic [R_W/2-1:0] root
);

  localparam int H_W   = R_W / 2;
  localparam int RM    = H_W + 3;
  localparam int CNT_W = $clog2(H_W + 1);

  logic [R_W-1:0]   rad_r;
  logic [RM-1:0]    rem_r;
  logic [H_W-1:0]   root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RM-1:0]    rem_sh;
  logic [RM-1:0]    trial;
  logic             ge;

  // one result bit per cycle, restoring
  assign rem_sh = {rem_r[RM-3:0], rad_r[R_W-1:R_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(H_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[R_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[H_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/gaps_ctrl.sv]
module gaps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  gaps_pkg::gaps_sts_t sts,
  output gaps_pkg::gaps_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GCHK = 4'd1;
  localparam logic [3:0] S_GDAT = 4'd2;
  localparam logic [3:0] S_SEL  = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_POP  = 4'd5;
  localparam logic [3:0] S_EXP  = 4'd6;
  localparam logic [3:0] S_EXPW = 4'd7;
  localparam logic [3:0] S_SQ   = 4'd8;
  localparam logic [3:0] S_BTR  = 4'd9;
  localparam logic [3:0] S_BTD  = 4'd10;
  localparam logic [3:0] S_EMI  = 4'd11;
  localparam logic [3:0] S_EMR  = 4'd12;
  localparam logic [3:0] S_EML  = 4'd13;
  localparam logic [3:0] S_EMW  = 4'd14;
  localparam logic [3:0] S_FAIL = 4'd15;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.in_vld) begin
          if (sts.in_op == gaps_pkg::OP_QUERY) begin
            cmd.q_init = 1'b1;
            state_nxt  = S_GCHK;
          end else begin
            cmd.grid_wr = 1'b1;
          end
        end
      end
      S_GCHK: begin
        cmd.goal_rd = 1'b1;
        state_nxt   = S_GDAT;
      end
      S_GDAT: begin
        if (sts.goal_wall) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.open_seed = 1'b1;
          state_nxt     = S_SEL;
        end
      end
      S_SEL: begin
        if (sts.live_zero) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.scan_more && !sts.scan_pend) begin
          state_nxt = S_POP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_POP: begin
        if (sts.closed_full) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = sts.cur_goal ? S_BTR : S_EXP;
        end
      end
      S_EXP: begin
        if (sts.nb_in) begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_EXPW;
        end else if (sts.d_last) begin
          state_nxt = S_SEL;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      S_EXPW: begin
        if (sts.child_ok) begin
          cmd.sq_start = 1'b1;
          state_nxt    = S_SQ;
        end else if (sts.d_last) begin
          state_nxt = S_SEL;
        end else begin
          cmd.nb_next = 1'b1;
          state_nxt   = S_EXP;
        end
      end
      S_SQ: begin
        if (sts.sq_done) begin
          cmd.child_wr = 1'b1;
          if (sts.d_last) begin
            state_nxt = S_SEL;
          end else begin
            cmd.nb_next = 1'b1;
            state_nxt   = S_EXP;
          end
        end
      end
      S_BTR: begin
        state_nxt = S_BTD;
      end
      S_BTD: begin
        cmd.bt_take = 1'b1;
        state_nxt   = sts.bt_stop ? S_EMI : S_BTR;
      end
      S_EMI: begin
        cmd.em_init = 1'b1;
        state_nxt   = S_EMR;
      end
      S_EMR: begin
        state_nxt = S_EML;
      end
      S_EML: begin
        cmd.em_load = 1'b1;
        state_nxt   = S_EMW;
      end
      S_EMW: begin
        if (!sts.out_vld) begin
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.em_next = 1'b1;
            state_nxt   = S_EMR;
          end
        end
      end
      S_FAIL: begin
        cmd.fail_load = 1'b1;
        state_nxt     = S_EMW;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/gaps_dp.sv]
module gaps_dp #(
  parameter int LIST_DEPTH = gaps_pkg::LIST_DEPTH,
  parameter int FRAC_BITS  = gaps_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gaps_pkg::gaps_cmd_t cmd,
  output gaps_pkg::gaps_sts_t sts,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic [2:0]          in_cell_x,
  input  logic [2:0]          in_cell_y,
  input  logic [1:0]          in_cell_value,
  input  logic [2:0]          in_start_x,
  input  logic [2:0]          in_start_y,
  input  logic [2:0]          in_goal_x,
  input  logic [2:0]          in_goal_y,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          out_path_x,
  output logic [2:0]          out_path_y,
  output logic                out_found,
  output logic                out_last
);

  localparam int CELL_W  = gaps_pkg::CELL_W;
  localparam int CELLS   = gaps_pkg::CELLS;
  localparam int G_W     = gaps_pkg::G_W;
  localparam int CW      = $clog2(LIST_DEPTH);
  localparam int LC_W    = $clog2(LIST_DEPTH + 1);
  localparam int SL_W    = $clog2(CELLS);
  localparam int SC_W    = $clog2(CELLS + 1);
  localparam int RAD_RAW = gaps_pkg::D2_W + 2 * FRAC_BITS;
  localparam int R_W     = RAD_RAW + (RAD_RAW % 2);
  localparam int H_W     = R_W / 2;
  localparam int F_W     = G_W + FRAC_BITS;
  localparam int OW      = CELL_W + CW + G_W + F_W;
  localparam int CDW     = CELL_W + CW;

  // query and search state
  logic [2:0]        sx_r, sy_r, gx_r, gy_r;
  logic [CELLS-1:0]  grid_vld_r;
  logic [CELLS-1:0]  open_flag_r;
  logic [CELLS-1:0]  closed_flag_r;
  logic [SL_W-1:0]   grid_rd_idx_r;
  logic [SC_W-1:0]   app_r;
  logic [SC_W-1:0]   scan_i_r;
  logic              scan_pend_r;
  logic [LC_W-1:0]   live_r;
  logic [LC_W-1:0]   closed_cnt_r;
  logic              best_vld_r;
  logic [F_W-1:0]    best_f_r;
  logic [G_W-1:0]    best_g_r;
  logic [CW-1:0]     best_par_r;
  logic [CELL_W-1:0] best_cell_r;
  logic [CELL_W-1:0] cur_cell_r;
  logic [G_W-1:0]    cur_g_r;
  logic [CW-1:0]     cur_idx_r;
  logic [2:0]        d_r;
  logic [CELL_W-1:0] nb_cell_r;
  logic [CW-1:0]     bt_idx_r;
  logic [LC_W-1:0]   len_r;
  logic [LC_W-1:0]   k_r;
  logic [LC_W-1:0]   n_r;
  logic              out_vld_r;
  logic [2:0]        out_x_r, out_y_r;
  logic              out_found_r;
  logic              out_last_r;

  // memory ports
  logic [1:0]        grid_rd;
  logic [SL_W-1:0]   grid_raddr;
  logic [OW-1:0]     open_wdata, open_rd;
  logic [CDW-1:0]    closed_rd;
  logic [CELL_W-1:0] chain_rd;
  logic [CW-1:0]     em_addr;

  // combinational
  logic [CELL_W-1:0] start_cell, goal_cell;
  logic [1:0]        grid_code;
  logic [4:0]        nx, ny;
  logic              nb_in;
  logic [CELL_W-1:0] nb_cell;
  logic [2:0]        ddx, ddy;
  logic [5:0]        ex, ey;
  logic [6:0]        d2;
  logic [R_W-1:0]    rad;
  logic              sq_busy, sq_done;
  logic [H_W-1:0]    h;
  logic [G_W-1:0]    g1;
  logic [F_W-1:0]    f_child;
  logic [CELL_W-1:0] rd_cell;
  logic [CW-1:0]     rd_par;
  logic [G_W-1:0]    rd_g;
  logic [F_W-1:0]    rd_f;
  logic              take_best;
  logic [CELL_W-1:0] cl_cell;
  logic [CW-1:0]     cl_par;
  logic [LC_W-1:0]   n_val;

  assign start_cell = {sy_r, sx_r};
  assign goal_cell  = {gy_r, gx_r};

  assign nx      = {2'b00, cur_cell_r[2:0]} + {gaps_pkg::STEP_DX[d_r][3], gaps_pkg::STEP_DX[d_r]};
  assign ny      = {2'b00, cur_cell_r[5:3]} + {gaps_pkg::STEP_DY[d_r][3], gaps_pkg::STEP_DY[d_r]};
  assign nb_in   = !nx[4] && !ny[4] && (nx < 5'(gaps_pkg::GRID_W)) && (ny < 5'(gaps_pkg::GRID_H));
  assign nb_cell = {ny[2:0], nx[2:0]};

  assign grid_raddr = cmd.goal_rd ? goal_cell : nb_cell;
  assign grid_code  = grid_vld_r[grid_rd_idx_r] ? grid_rd : gaps_pkg::CODE_WALK;

  assign ddx = (nb_cell_r[2:0] >= gx_r) ? (nb_cell_r[2:0] - gx_r) : (gx_r - nb_cell_r[2:0]);
  assign ddy = (nb_cell_r[5:3] >= gy_r) ? (nb_cell_r[5:3] - gy_r) : (gy_r - nb_cell_r[5:3]);
  assign ex  = {3'b000, ddx};
  assign ey  = {3'b000, ddy};
  assign d2  = 7'(ex * ex) + 7'(ey * ey);
  assign rad = R_W'({d2, {(2 * FRAC_BITS){1'b0}}});

  assign g1      = cur_g_r + G_W'(1);
  assign f_child = F_W'({g1, {FRAC_BITS{1'b0}}}) + F_W'(h);

  assign rd_f    = open_rd[F_W-1:0];
  assign rd_g    = open_rd[F_W +: G_W];
  assign rd_par  = open_rd[F_W+G_W +: CW];
  assign rd_cell = open_rd[F_W+G_W+CW +: CELL_W];
  assign take_best = scan_pend_r && open_flag_r[rd_cell] && (!best_vld_r || (best_f_r > rd_f));

  assign cl_par  = closed_rd[CW-1:0];
  assign cl_cell = closed_rd[CW +: CELL_W];

  assign open_wdata = cmd.open_seed ? {start_cell, {CW{1'b0}}, {G_W{1'b0}}, {F_W{1'b0}}}
                                    : {nb_cell_r, cur_idx_r, g1, f_child};

  assign em_addr = CW'(len_r - LC_W'(1) - k_r);
  assign n_val   = (32'(len_r) > 32'(gaps_pkg::MAX_OUT)) ? LC_W'(gaps_pkg::MAX_OUT) : len_r;

  gaps_ram #(.W(2), .D(CELLS)) u_grid (
    .clk   (clk),
    .we    (cmd.grid_wr),
    .waddr ({in_cell_y, in_cell_x}),
    .wdata (in_cell_value),
    .raddr (grid_raddr),
    .rdata (grid_rd)
  );

  gaps_ram #(.W(OW), .D(CELLS)) u_open (
    .clk   (clk),
    .we    (cmd.open_seed || cmd.child_wr),
    .waddr (app_r[SL_W-1:0]),
    .wdata (open_wdata),
    .raddr (scan_i_r[SL_W-1:0]),
    .rdata (open_rd)
  );

  gaps_ram #(.W(CDW), .D(LIST_DEPTH)) u_closed (
    .clk   (clk),
    .we    (cmd.pop),
    .waddr (closed_cnt_r[CW-1:0]),
    .wdata ({best_cell_r, best_par_r}),
    .raddr (bt_idx_r),
    .rdata (closed_rd)
  );

  gaps_ram #(.W(CELL_W), .D(LIST_DEPTH)) u_chain (
    .clk   (clk),
    .we    (cmd.bt_take),
    .waddr (len_r[CW-1:0]),
    .wdata (cl_cell),
    .raddr (em_addr),
    .rdata (chain_rd)
  );

  gaps_sqrt #(.R_W(R_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sq_start),
    .rad   (rad),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (h)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_vld_r    <= '0;
      open_flag_r   <= '0;
      closed_flag_r <= '0;
      app_r         <= '0;
      scan_i_r      <= '0;
      scan_pend_r   <= 1'b0;
      live_r        <= '0;
      closed_cnt_r  <= '0;
      best_vld_r    <= 1'b0;
      d_r           <= '0;
      len_r         <= '0;
      k_r           <= '0;
      n_r           <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cmd.grid_wr) begin
        grid_vld_r[{in_cell_y, in_cell_x}] <= 1'b1;
      end
      if (cmd.q_init) begin
        open_flag_r   <= '0;
        closed_flag_r <= '0;
        app_r         <= '0;
        live_r        <= '0;
        closed_cnt_r  <= '0;
      end
      if (cmd.open_seed) begin
        open_flag_r[start_cell] <= 1'b1;
        app_r  <= app_r + SC_W'(1);
        live_r <= live_r + LC_W'(1);
      end
      if (cmd.scan_clr) begin
        scan_i_r    <= '0;
        scan_pend_r <= 1'b0;
        best_vld_r  <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_pend_r <= (scan_i_r < app_r);
        if (scan_i_r < app_r) begin
          scan_i_r <= scan_i_r + SC_W'(1);
        end
        if (take_best) begin
          best_vld_r <= 1'b1;
        end
      end
      if (cmd.pop) begin
        open_flag_r[best_cell_r]   <= 1'b0;
        closed_flag_r[best_cell_r] <= 1'b1;
        live_r       <= live_r - LC_W'(1);
        closed_cnt_r <= closed_cnt_r + LC_W'(1);
        d_r          <= '0;
        len_r        <= '0;
      end
      if (cmd.nb_next) begin
        d_r <= d_r + 3'd1;
      end
      if (cmd.child_wr) begin
        open_flag_r[nb_cell_r] <= 1'b1;
        app_r  <= app_r + SC_W'(1);
        live_r <= live_r + LC_W'(1);
      end
      if (cmd.bt_take) begin
        len_r <= len_r + LC_W'(1);
      end
      if (cmd.em_init) begin
        k_r <= '0;
        n_r <= n_val;
      end
      if (cmd.em_next) begin
        k_r <= k_r + LC_W'(1);
      end
      if (cmd.em_load || cmd.fail_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    grid_rd_idx_r <= grid_raddr;
    if (cmd.q_init) begin
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      gx_r <= in_goal_x;
      gy_r <= in_goal_y;
    end
    if (cmd.scan_step && take_best) begin
      best_f_r    <= rd_f;
      best_g_r    <= rd_g;
      best_par_r  <= rd_par;
      best_cell_r <= rd_cell;
    end
    if (cmd.pop) begin
      cur_cell_r <= best_cell_r;
      cur_g_r    <= best_g_r;
      cur_idx_r  <= closed_cnt_r[CW-1:0];
      bt_idx_r   <= closed_cnt_r[CW-1:0];
    end
    if (cmd.nb_rd) begin
      nb_cell_r <= nb_cell;
    end
    if (cmd.bt_take) begin
      bt_idx_r <= cl_par;
    end
    if (cmd.em_load) begin
      out_x_r     <= chain_rd[2:0];
      out_y_r     <= chain_rd[5:3];
      out_found_r <= 1'b1;
      out_last_r  <= (k_r == n_r - LC_W'(1));
    end else if (cmd.fail_load) begin
      out_x_r     <= sx_r;
      out_y_r     <= sy_r;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  always_comb begin
    sts             = '0;
    sts.in_vld      = in_valid;
    sts.in_op       = in_op;
    sts.goal_wall   = (grid_code == gaps_pkg::CODE_WALL);
    sts.live_zero   = (live_r == '0);
    sts.scan_more   = (scan_i_r < app_r);
    sts.scan_pend   = scan_pend_r;
    sts.closed_full = (closed_cnt_r >= LC_W'(LIST_DEPTH));
    sts.cur_goal    = (best_cell_r == goal_cell);
    sts.nb_in       = nb_in;
    sts.d_last      = (d_r == 3'd7);
    sts.child_ok    = (grid_code == gaps_pkg::CODE_WALK) && !open_flag_r[nb_cell_r] &&
                      !closed_flag_r[nb_cell_r] && (live_r < LC_W'(LIST_DEPTH));
    sts.sq_done     = sq_done;
    sts.bt_stop     = (cl_cell == start_cell) || (len_r + LC_W'(1) == LC_W'(LIST_DEPTH)) ||
                      (LC_W'(cl_par) >= closed_cnt_r);
    sts.out_vld     = out_vld_r;
    sts.out_last    = out_last_r;
  end

  assign out_valid  = out_vld_r;
  assign out_path_x = out_x_r;
  assign out_path_y = out_y_r;
  assign out_found  = out_found_r;
  assign out_last   = out_last_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LC_W'(LIST_DEPTH))
    else $error("open list count over depth");

  a_child_new: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.child_wr |-> (live_r < LC_W'(LIST_DEPTH)) && !open_flag_r[nb_cell_r] &&
                     !closed_flag_r[nb_cell_r])
    else $error("child written to full list or duplicate cell");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sq_start |-> !sq_busy)
    else $error("square root started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.em_load || cmd.fail_load) |-> !out_vld_r)
    else $error("result overwritten before taken");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> closed_flag_r[cur_cell_r] && !open_flag_r[cur_cell_r])
    else $error("expanded cell not moved to closed list");

endmodule

[rtl/grid_astar_path_search_core.sv]
// Grid path search: a load request (op 0) writes one 2-bit code of the 8x8 map.
// A query request (op 1) runs 8-connected A* from start to goal and returns the path cells
// from start to goal, one result each, with last on the final one; a wall goal or an
// unreachable goal returns the start cell alone with found clear. One request is handled at
// a time. A query runs a setup, then per expanded cell one pass over the open list RAM
// (one entry per cycle, up to 64, plus select and pop) plus up to 8 neighbor checks,
// each accepted neighbor adding a bit-serial square root for the heuristic, then a
// back-trace over the path cells and the emission of each cell, which output stalls can
// hold. The open list scan and the square root set the worst case.
module grid_astar_path_search_core #(
  parameter int LIST_DEPTH = gaps_pkg::LIST_DEPTH,
  parameter int FRAC_BITS  = gaps_pkg::FRAC_BITS
) (
  input logic          clk,
  input logic          rst_n,
  gaps_in_if.sink      in_ch,
  gaps_out_if.source   out_ch
);

  gaps_pkg::gaps_cmd_t cmd;
  gaps_pkg::gaps_sts_t sts;

  gaps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  gaps_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_valid      (in_ch.valid),
    .in_op         (in_ch.op),
    .in_cell_x     (in_ch.cell_x),
    .in_cell_y     (in_ch.cell_y),
    .in_cell_value (in_ch.cell_value),
    .in_start_x    (in_ch.start_x),
    .in_start_y    (in_ch.start_y),
    .in_goal_x     (in_ch.goal_x),
    .in_goal_y     (in_ch.goal_y),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_path_x    (out_ch.path_x),
    .out_path_y    (out_ch.path_y),
    .out_found     (out_ch.found),
    .out_last      (out_ch.last)
  );

  assign in_ch.ready = cmd.in_rdy;

endmodule

[sim/tb_gaps_ifs.sv]
`timescale 1ns / 100ps
// The testbench instantiates the channel interfaces from rtl/gaps_if.sv.
// This file holds no other declarations.

[sim/tb.sv]
`timescale 1ns / 100ps
module tb;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic       found;
    logic       last;
  } path_cell_t;

  typedef struct {
    logic [2:0]  x;
    logic [2:0]  y;
    logic [6:0]  parent;
    logic [31:0] g;
    logic [31:0] f;
  } node_t;

  logic clk;
  logic rst_n;
  int   errors;

  gaps_in_if  in_ch ();
  gaps_out_if out_ch ();

  grid_astar_path_search_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [1:0]  map_code [gaps_pkg::CELLS];
  path_cell_t  path_q   [$];
  node_t       open_l   [gaps_pkg::LIST_DEPTH];
  node_t       closed_l [gaps_pkg::LIST_DEPTH];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] dist_h(int x, int y, int gx, int gy);
    logic [63:0] dx;
    logic [63:0] dy;
    dx = 64'((x > gx) ? x - gx : gx - x);
    dy = 64'((y > gy) ? y - gy : gy - y);
    return isqrt((dx * dx + dy * dy) << (2 * gaps_pkg::FRAC_BITS));
  endfunction

  task automatic enqueue_cell(logic [2:0] x, logic [2:0] y, logic found, logic last);
    path_cell_t pc;
    pc = '{x: x, y: y, found: found, last: last};
    path_q = {path_q, pc};
  endtask

  task automatic predict_path(int sx, int sy, int gx, int gy);
    int     n_open;
    int     n_closed;
    int     best;
    int     cur_idx;
    int     len;
    int     idx;
    int     nx;
    int     ny;
    bit     seen;
    node_t  cur;
    int     chain [gaps_pkg::LIST_DEPTH];
    n_open = 0;
    n_closed = 0;
    if (map_code[gy * gaps_pkg::GRID_W + gx] != gaps_pkg::CODE_WALL) begin
      open_l[0] = '{x: 3'(sx), y: 3'(sy), parent: 7'd0, g: 32'd0, f: 32'd0};
      n_open = 1;
    end
    while (n_open != 0) begin
      best = 0;
      for (int i = 1; i < n_open; i++)
        if (open_l[best].f > open_l[i].f) best = i;
      cur = open_l[best];
      for (int i = best; i + 1 < n_open; i++) open_l[i] = open_l[i + 1];
      n_open--;
      if (n_closed >= gaps_pkg::LIST_DEPTH) break;
      cur_idx = n_closed;
      closed_l[n_closed++] = cur;
      if (cur.x == gx && cur.y == gy) begin
        len = 0;
        idx = cur_idx;
        while (len < gaps_pkg::LIST_DEPTH) begin
          chain[len++] = idx;
          if (closed_l[idx].x == sx && closed_l[idx].y == sy) break;
          idx = int'(closed_l[idx].parent);
          if (idx >= n_closed) break;
        end
        for (int k = 0; k < len; k++)
          enqueue_cell(closed_l[chain[len - 1 - k]].x, closed_l[chain[len - 1 - k]].y,
                       1'b1, k == len - 1);
        return;
      end
      for (int d = 0; d < gaps_pkg::DIRS; d++) begin
        nx = int'(cur.x) + gaps_pkg::STEP_DX[d];
        ny = int'(cur.y) + gaps_pkg::STEP_DY[d];
        if (nx < 0 || ny < 0 || nx >= gaps_pkg::GRID_W || ny >= gaps_pkg::GRID_H) continue;
        if (map_code[ny * gaps_pkg::GRID_W + nx] != gaps_pkg::CODE_WALK) continue;
        seen = 0;
        for (int i = 0; i < n_closed; i++)
          if (closed_l[i].x == nx && closed_l[i].y == ny) seen = 1;
        for (int i = 0; i < n_open; i++)
          if (open_l[i].x == nx && open_l[i].y == ny) seen = 1;
        if (seen || n_open >= gaps_pkg::LIST_DEPTH) continue;
        open_l[n_open] = '{x: 3'(nx), y: 3'(ny), parent: 7'(cur_idx), g: cur.g + 32'd1,
                           f: ((cur.g + 32'd1) << gaps_pkg::FRAC_BITS) +
                              dist_h(nx, ny, gx, gy)};
        n_open++;
      end
    end
    enqueue_cell(3'(sx), 3'(sy), 1'b0, 1'b1);
  endtask

  task automatic send_req(logic op, logic [2:0] cx, logic [2:0] cy, logic [1:0] cv,
                          logic [2:0] sx, logic [2:0] sy, logic [2:0] gx, logic [2:0] gy);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.cell_x     <= cx;
    in_ch.cell_y     <= cy;
    in_ch.cell_value <= cv;
    in_ch.start_x    <= sx;
    in_ch.start_y    <= sy;
    in_ch.goal_x     <= gx;
    in_ch.goal_y     <= gy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == gaps_pkg::OP_LOAD) map_code[cy * gaps_pkg::GRID_W + cx] = cv;
    else predict_path(int'(sx), int'(sy), int'(gx), int'(gy));
  endtask

  task automatic load_cell(int x, int y, logic [1:0] v);
    send_req(gaps_pkg::OP_LOAD, 3'(x), 3'(y), v, 3'($urandom), 3'($urandom),
             3'($urandom), 3'($urandom));
  endtask

  task automatic query(int sx, int sy, int gx, int gy);
    send_req(gaps_pkg::OP_QUERY, 3'($urandom), 3'($urandom), 2'($urandom),
             3'(sx), 3'(sy), 3'(gx), 3'(gy));
    in_ch.valid <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_open_map;
    query(0, 0, 7, 7);
    query(7, 7, 0, 0);
    query(3, 4, 3, 4);
    query(7, 0, 0, 7);
  endtask

  task automatic test_blocked_goals;
    load_cell(5, 5, gaps_pkg::CODE_WALL);
    query(0, 0, 5, 5);
    load_cell(6, 1, 2'd2);
    query(0, 1, 6, 1);
    load_cell(6, 1, 2'd3);
    query(6, 1, 6, 1);
    load_cell(2, 2, 2'd3);
    query(2, 2, 4, 2);
  endtask

  task automatic test_walls;
    for (int y = 0; y < 7; y++) load_cell(4, y, gaps_pkg::CODE_WALL);
    query(0, 0, 7, 0);
    load_cell(4, 7, gaps_pkg::CODE_WALL);
    query(0, 0, 7, 0);
    for (int y = 0; y < 8; y++) load_cell(4, y, gaps_pkg::CODE_WALK);
    load_cell(6, 1, gaps_pkg::CODE_WALK);
    load_cell(2, 2, gaps_pkg::CODE_WALK);
    load_cell(5, 5, gaps_pkg::CODE_WALK);
  endtask

  task automatic test_random;
    int x;
    int y;
    for (int n = 0; n < 70; n++) begin
      x = $urandom_range(0, 7);
      y = $urandom_range(0, 7);
      if ($urandom_range(0, 3) != 0)
        load_cell(x, y, ($urandom_range(0, 1) == 0) ? gaps_pkg::CODE_WALK :
                        ($urandom_range(0, 4) != 0) ? gaps_pkg::CODE_WALL :
                        2'($urandom_range(2, 3)));
      else
        query($urandom_range(0, 7), $urandom_range(0, 7), x, y);
    end
  endtask

  initial begin
    int w;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      w = $urandom_range(0, 4);
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (path_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d found=%0d last=%0d", $time,
                 out_ch.path_x, out_ch.path_y, out_ch.found, out_ch.last);
        errors++;
      end else begin
        if (path_q[0] !== {out_ch.path_x, out_ch.path_y, out_ch.found, out_ch.last}) begin
          $display("%0t: expected x=%0d y=%0d found=%0d last=%0d, got %0d %0d %0d %0d",
                   $time, path_q[0].x, path_q[0].y, path_q[0].found, path_q[0].last,
                   out_ch.path_x, out_ch.path_y, out_ch.found, out_ch.last);
          errors++;
        end
        void'(path_q.pop_front());
      end
    end
  end

  initial begin
    errors = 0;
    for (int c = 0; c < gaps_pkg::CELLS; c++) map_code[c] = gaps_pkg::CODE_WALK;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= gaps_pkg::OP_LOAD;
    in_ch.cell_x <= 3'd0;
    in_ch.cell_y <= 3'd0;
    in_ch.cell_value <= 2'd0;
    in_ch.start_x <= 3'd0;
    in_ch.start_y <= 3'd0;
    in_ch.goal_x <= 3'd0;
    in_ch.goal_y <= 3'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_open_map();
    test_blocked_goals();
    test_walls();
    test_random();
    in_ch.valid <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("grid_astar_path_search_core regression: pass");
    else $display("grid_astar_path_search_core regression: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("grid_astar_path_search_core regression: fail");
    $finish;
  end
endmodule

[grid_astar_path_search_core.f]
rtl/gaps_pkg.sv
rtl/gaps_if.sv
rtl/gaps_ram.sv
rtl/gaps_sqrt.sv
rtl/gaps_ctrl.sv
rtl/gaps_dp.sv
rtl/grid_astar_path_search_core.sv
sim/tb_gaps_ifs.sv
sim/tb.sv
